@@ design/apzd_pkg.sv @@
// Package for the APZ frame deframer: result and queue entry types,
// word codes, status codes and queue sizing. No dependencies.
package apzd_pkg;

    localparam logic [31:0] END_MARK    = 32'hFAFA_FAFA;
    localparam logic [23:0] HDR_TAG     = 24'h41_505A;
    localparam logic [2:0]  SKIP_POS    = 3'd7;
    localparam logic [2:0]  START_POS   = 3'd0;
    localparam logic [2:0]  CARD_POS    = 3'd2;
    localparam logic [7:0]  MAX_CHANNEL = 8'd15;

    localparam logic [1:0] ST_DATA     = 2'd0;
    localparam logic [1:0] ST_CHAN_ERR = 2'd1;
    localparam logic [1:0] ST_ABANDON  = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  card_id;
        logic [7:0]  channel;
        logic [15:0] frame_size;
        logic [31:0] data_word;
        logic        frame_last;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    function automatic result_t make_result(
        input logic [1:0]  status,
        input logic [7:0]  card_id,
        input logic [7:0]  channel,
        input logic [15:0] frame_size,
        input logic [31:0] data_word,
        input logic        frame_last
    );
        result_t r;
        r.status     = status;
        r.card_id    = card_id;
        r.channel    = channel;
        r.frame_size = frame_size;
        r.data_word  = data_word;
        r.frame_last = frame_last;
        return r;
    endfunction

endpackage

@@ design/apzd_if.sv @@
// Channel interfaces of the APZ frame deframer: input words and results.
// Standalone; widths follow the package fields.
interface apzd_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        buffer_end;

    modport source (output valid, output word, output buffer_end, input ready);
    modport sink   (input valid, input word, input buffer_end, output ready);
endinterface

interface apzd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  card_id;
    logic [7:0]  channel;
    logic [15:0] frame_size;
    logic [31:0] data_word;
    logic        frame_last;

    modport source (output valid, output status, output card_id, output channel,
                    output frame_size, output data_word, output frame_last, input ready);
    modport sink   (input valid, input status, input card_id, input channel,
                    input frame_size, input data_word, input frame_last, output ready);
endinterface

@@ design/apzd_front.sv @@
// Front end: accepts buffer words, tracks event and frame state, holds two
// words back for trailer detection and packs up to two results per word.
// Depends on apzd_pkg and apzd_word_if.
module apzd_front (
    input  logic             clk,
    input  logic             rst_n,
    apzd_word_if.sink        words,
    output apzd_pkg::entry_t push_entry,
    output logic             push_valid,
    input  logic             push_ready
);
    import apzd_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  card_reg, card_next;
    logic [3:0]  chan_reg, chan_next;
    logic [15:0] size_reg, size_next;
    logic        expect_reg, expect_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        started_reg, started_next;
    logic        finished_reg, finished_next;
    logic [31:0] held0_reg, held0_next;
    logic [31:0] held1_reg, held1_next;

    logic        accept;
    logic [31:0] w;
    logic [7:0]  chan_ext;
    logic [1:0]  n;
    result_t     res [2];

    assign w          = words.word;
    assign accept     = words.valid && push_ready;
    assign words.ready = push_ready;
    assign chan_ext   = {4'b0, chan_reg};

    always_comb
    begin
        pos_next      = pos_reg;
        card_next     = card_reg;
        chan_next     = chan_reg;
        size_next     = size_reg;
        expect_next   = expect_reg;
        cnt_next      = cnt_reg;
        started_next  = started_reg;
        finished_next = finished_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        res[0]        = '0;
        res[1]        = '0;
        n             = 2'd0;

        if (pos_reg < SKIP_POS)
        begin
            if (pos_reg == START_POS)
            begin
                chan_next = '0;
                size_next = '0;
            end
            if (pos_reg == CARD_POS)
            begin
                card_next = w[7:0];
            end
            pos_next = pos_reg + 3'd1;
        end
        else if (!finished_reg)
        begin
            if (w == END_MARK)
            begin
                if (cnt_reg == 2'd2)
                begin
                    res[0] = make_result(ST_DATA, card_reg, chan_ext, size_reg, held0_reg, 1'b0);
                    res[1] = make_result(ST_DATA, card_reg, chan_ext, size_reg, held1_reg, 1'b1);
                    n      = 2'd2;
                end
                else if (cnt_reg == 2'd1)
                begin
                    res[0] = make_result(ST_DATA, card_reg, chan_ext, size_reg, held0_reg, 1'b1);
                    n      = 2'd1;
                end
                cnt_next      = '0;
                expect_next   = 1'b0;
                started_next  = 1'b0;
                finished_next = 1'b1;
            end
            else if (expect_reg)
            begin
                size_next   = w[15:0];
                cnt_next    = '0;
                expect_next = 1'b0;
            end
            else if (w[31:8] == HDR_TAG)
            begin
                if (cnt_reg == 2'd2)
                begin
                    res[0] = make_result(ST_DATA, card_reg, chan_ext, size_reg, held0_reg, 1'b1);
                    n      = 2'd1;
                end
                cnt_next = '0;
                if (w[7:0] > MAX_CHANNEL)
                begin
                    res[n[0]]     = make_result(ST_CHAN_ERR, card_reg, w[7:0], size_reg,
                                                32'd0, 1'b0);
                    n             = n + 2'd1;
                    started_next  = 1'b0;
                    finished_next = 1'b1;
                end
                else
                begin
                    chan_next    = w[3:0];
                    expect_next  = 1'b1;
                    started_next = 1'b1;
                end
            end
            else if (cnt_reg == 2'd2)
            begin
                res[0]     = make_result(ST_DATA, card_reg, chan_ext, size_reg, held0_reg, 1'b0);
                n          = 2'd1;
                held0_next = held1_reg;
                held1_next = w;
            end
            else if (cnt_reg == 2'd0)
            begin
                held0_next = w;
                cnt_next   = 2'd1;
            end
            else
            begin
                held1_next = w;
                cnt_next   = 2'd2;
            end
        end

        if (words.buffer_end)
        begin
            if (!finished_next && (started_next || expect_next || cnt_next != 2'd0))
            begin
                res[n[0]] = make_result(ST_ABANDON, card_next, {4'b0, chan_next}, size_next,
                                        32'd0, 1'b0);
                n         = n + 2'd1;
            end
            pos_next      = '0;
            chan_next     = '0;
            size_next     = '0;
            expect_next   = 1'b0;
            cnt_next      = '0;
            started_next  = 1'b0;
            finished_next = 1'b0;
        end
    end

    assign push_valid    = accept && (n != 2'd0);
    assign push_entry.two = n[1];
    assign push_entry.r0  = res[0];
    assign push_entry.r1  = res[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            card_reg     <= '0;
            chan_reg     <= '0;
            size_reg     <= '0;
            expect_reg   <= 1'b0;
            cnt_reg      <= '0;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            card_reg     <= card_next;
            chan_reg     <= chan_next;
            size_reg     <= size_next;
            expect_reg   <= expect_next;
            cnt_reg      <= cnt_next;
            started_reg  <= started_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

@@ design/apzd_queue.sv @@
// Small queue of result entries between front and back ends.
// Depends on apzd_pkg.
module apzd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  apzd_pkg::entry_t push_entry,
    input  logic             push_valid,
    output logic             push_ready,
    output apzd_pkg::entry_t pop_entry,
    output logic             pop_valid,
    input  logic             pop_ready
);
    import apzd_pkg::*;

    entry_t         mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != QDEPTH[QAW:0]);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/apzd_back.sv @@
// Back end: drains queue entries into the output register one result
// per cycle while results.ready. Depends on apzd_pkg, apzd_result_if.
module apzd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  apzd_pkg::entry_t pop_entry,
    input  logic             pop_valid,
    output logic             pop_ready,
    apzd_result_if.source    results
);
    import apzd_pkg::*;

    result_t out_reg;
    result_t second_reg;
    logic    out_valid_reg;
    logic    pending_reg;
    logic    advance;

    assign advance   = !out_valid_reg || results.ready;
    assign pop_ready = advance && !pending_reg;

    assign results.valid      = out_valid_reg;
    assign results.status     = out_reg.status;
    assign results.card_id    = out_reg.card_id;
    assign results.channel    = out_reg.channel;
    assign results.frame_size = out_reg.frame_size;
    assign results.data_word  = out_reg.data_word;
    assign results.frame_last = out_reg.frame_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (pending_reg)
            begin
                out_valid_reg <= 1'b1;
                pending_reg   <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pop_valid;
                pending_reg   <= pop_valid && pop_entry.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (pending_reg)
            begin
                out_reg <= second_reg;
            end
            else if (pop_valid)
            begin
                out_reg    <= pop_entry.r0;
                second_reg <= pop_entry.r1;
            end
        end
    end

endmodule

@@ design/apz_frame_deframer_unit.sv @@
// APZ frame deframer top level: front end, entry queue and back end.
// Depends on apzd_pkg, apzd_if, apzd_front, apzd_queue and apzd_back.
//
// Usage: words carries one 32-bit buffer word per handshake, buffer_end
// set on the last word of each event buffer. results carries tagged
// payload words, channel errors and abandoned-frame reports.
// Throughput: one word per cycle while the queue has room; a word can
// cause up to two results, and the back end sends one result per cycle
// while the receiver is ready, so a run of two-result words is limited by
// the output port and absorbed by a four-entry queue. A word's results
// are written to the queue at the accepting edge, then loaded into the
// output register; a second result follows via the back end's second_reg.
// Words ready drops only when the queue is full; a stalled receiver holds
// the output register and backs up the queue, then the input.
// Reset clears all event state, the card id, the queue and output valid.
module apz_frame_deframer_unit (
    input  logic          clk,
    input  logic          rst_n,
    apzd_word_if.sink     words,
    apzd_result_if.source results
);
    import apzd_pkg::*;

    entry_t push_entry;
    logic   push_valid;
    logic   push_ready;
    entry_t pop_entry;
    logic   pop_valid;
    logic   pop_ready;

    apzd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .words      (words),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    apzd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    apzd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_entry (pop_entry),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .results   (results)
    );

endmodule
